// ----- hw/rtl/mbss_pkg.sv -----
// Package for the masked byte signature scanner.
// Holds the register indexes, the configuration bundle and shared constants.
// No dependencies.
`default_nettype none

package mbss_pkg;

  // Default sizing of the scanner.
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int POSITION_BITS     = 32;

  // Fixed register widths.
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int LEN_W       = 5;
  localparam int OFFSET_W    = 32;
  localparam int ADDR_W      = 64;
  localparam int PATTERN_W   = 128;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_MASK_LOW     = 3'd2,
    REG_MASK_HIGH    = 3'd3,
    REG_PATTERN_LEN  = 3'd4,
    REG_RESULT_OFF   = 3'd5,
    REG_BASE_ADDR    = 3'd6
  } reg_index_t;

  // Register contents as seen by the datapath.
  typedef struct packed {
    logic [PATTERN_W-1:0] pattern;
    logic [PATTERN_W-1:0] mask;
    logic [LEN_W-1:0]     pattern_length;
    logic [OFFSET_W-1:0]  result_offset;
    logic [ADDR_W-1:0]    base_address;
  } cfg_t;

  // Control of the captured window stage.
  typedef struct packed {
    logic valid;
    logic last;
  } snap_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mbss_cfg.sv -----
// Configuration register file of the masked byte signature scanner.
// Depends on mbss_pkg.
`default_nettype none

module mbss_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [mbss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [mbss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output mbss_pkg::cfg_t                          cfg
);

  mbss_pkg::cfg_t regs;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern        <= '0;
      regs.mask           <= '0;
      regs.pattern_length <= mbss_pkg::LEN_W'(1);
      regs.result_offset  <= '0;
      regs.base_address   <= '0;
    end else if (cfg_wr_en) begin
      case (mbss_pkg::reg_index_t'(cfg_index))
        mbss_pkg::REG_PATTERN_LOW:  regs.pattern[63:0]   <= cfg_wdata;
        mbss_pkg::REG_PATTERN_HIGH: regs.pattern[127:64] <= cfg_wdata;
        mbss_pkg::REG_MASK_LOW:     regs.mask[63:0]      <= cfg_wdata;
        mbss_pkg::REG_MASK_HIGH:    regs.mask[127:64]    <= cfg_wdata;
        mbss_pkg::REG_PATTERN_LEN:
          regs.pattern_length <= cfg_wdata[mbss_pkg::LEN_W-1:0];
        mbss_pkg::REG_RESULT_OFF:
          regs.result_offset <= cfg_wdata[mbss_pkg::OFFSET_W-1:0];
        mbss_pkg::REG_BASE_ADDR:    regs.base_address <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ----- hw/rtl/mbss_window.sv -----
// Input stage of the masked byte signature scanner: running byte window,
// saturating position counter and the captured copy handed to the compare.
// Depends on mbss_pkg.
`default_nettype none

module mbss_window #(
  parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES,
  parameter int POSITION_BITS     = mbss_pkg::POSITION_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                take,
  input  wire logic                                advance,
  input  wire logic [7:0]                          data_byte,
  input  wire logic                                last_byte,
  output mbss_pkg::snap_ctrl_t                     snap_ctrl,
  output logic [MAX_PATTERN_BYTES-1:0][7:0]        snap_window,
  output logic [POSITION_BITS-1:0]                 snap_position
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [MAX_PATTERN_BYTES-1:0][7:0] window;
  logic [MAX_PATTERN_BYTES-1:0][7:0] window_next;
  logic [POSITION_BITS-1:0]          position;
  logic [POSITION_BITS-1:0]          position_next;
  mbss_pkg::snap_ctrl_t              ctrl;

  // Shift the new byte in at the front; the position saturates.
  always_comb begin
    window_next[0] = data_byte;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      window_next[i] = window[i-1];
    end
    position_next = (position < POS_MAX) ? position + POSITION_BITS'(1) : position;
  end

  // Running state; the last byte of a region clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      position <= '0;
    end else if (take) begin
      if (last_byte) begin
        window   <= '0;
        position <= '0;
      end else begin
        window   <= window_next;
        position <= position_next;
      end
    end
  end

  // Captured copy for the compare stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
      ctrl.last  <= 1'b0;
    end else if (take) begin
      ctrl.valid <= 1'b1;
      ctrl.last  <= last_byte;
    end else if (advance) begin
      ctrl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      snap_window   <= window_next;
      snap_position <= position_next;
    end
  end

  assign snap_ctrl = ctrl;

endmodule

`default_nettype wire

// ----- hw/rtl/mbss_match.sv -----
// Compare stage of the masked byte signature scanner: masked window compare,
// address sum, first-match tracking and the result register.
// Depends on mbss_pkg.
`default_nettype none

module mbss_match #(
  parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES,
  parameter int POSITION_BITS     = mbss_pkg::POSITION_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mbss_pkg::cfg_t                      cfg,
  input  wire mbss_pkg::snap_ctrl_t                snap_ctrl,
  input  wire logic [MAX_PATTERN_BYTES-1:0][7:0]   snap_window,
  input  wire logic [POSITION_BITS-1:0]            snap_position,
  input  wire logic                                out_ready,
  output logic                                     advance,
  output logic                                     out_valid,
  output logic                                     out_found,
  output logic [mbss_pkg::ADDR_W-1:0]              out_address
);

  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam logic [mbss_pkg::LEN_W-1:0] LEN_MAX = mbss_pkg::LEN_W'(MAX_PATTERN_BYTES);

  logic                              match_reported;
  logic [mbss_pkg::LEN_W-1:0]        len;
  logic                              all_equal;
  logic                              hit;
  logic                              emit;
  logic [POSITION_BITS-1:0]          start;
  logic [mbss_pkg::ADDR_W-1:0]       address;

  // Active length: zero counts as one, too large clamps to the window depth.
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = mbss_pkg::LEN_W'(1);
    end else if (cfg.pattern_length > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = cfg.pattern_length;
    end
  end

  // Pattern byte j lines up with the window byte that arrived len-1-j beats ago.
  always_comb begin
    logic [mbss_pkg::LEN_W-1:0] idx;
    logic [7:0]                 w;
    all_equal = 1'b1;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      idx = len - mbss_pkg::LEN_W'(1) - mbss_pkg::LEN_W'(j);
      w   = snap_window[idx[IDX_W-1:0]];
      if (mbss_pkg::LEN_W'(j) < len) begin
        if ((w & cfg.mask[8*j +: 8]) != cfg.pattern[8*j +: 8]) begin
          all_equal = 1'b0;
        end
      end
    end
  end

  // Address of the match start plus the signed offset, modulo 2^64.
  always_comb begin
    start   = snap_position - POSITION_BITS'(len);
    address = cfg.base_address + mbss_pkg::ADDR_W'(start)
            + {{(mbss_pkg::ADDR_W-mbss_pkg::OFFSET_W){cfg.result_offset[mbss_pkg::OFFSET_W-1]}},
               cfg.result_offset};
  end

  assign hit     = !match_reported && (snap_position >= POSITION_BITS'(len)) && all_equal;
  assign emit    = hit || (snap_ctrl.last && !match_reported);
  assign advance = !out_valid || out_ready;

  // First-match flag, cleared at the end of each region.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_reported <= 1'b0;
    end else if (advance && snap_ctrl.valid) begin
      match_reported <= snap_ctrl.last ? 1'b0 : (match_reported || hit);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= snap_ctrl.valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_found   <= hit;
      out_address <= hit ? address : '0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/masked_byte_signature_scan_top.sv -----
// Masked byte signature scanner, top level.
// A result is registered after its byte is accepted: first in the window stage,
// then in the result register. Throughput: one byte per cycle while the result
// side is not stalled, limited by the single window compare per beat.
// Reset: synchronous rst clears registers (length goes to one), window, position and match flag.
// Depends on mbss_pkg, mbss_cfg, mbss_window and mbss_match.
`default_nettype none

module masked_byte_signature_scan_top #(
  parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES,
  parameter int POSITION_BITS     = mbss_pkg::POSITION_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration write port.
  input  wire logic                               cfg_wr_en,
  input  wire logic [mbss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [mbss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Byte stream in.
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [7:0]                         s_tdata,   // [7:0] data_byte
  input  wire logic                               s_tlast,   // last_byte
  // Result stream out.
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [mbss_pkg::ADDR_W-1:0]             m_tdata,   // [63:0] match_address
  output logic                                    m_tuser    // found
);

  mbss_pkg::cfg_t                    cfg;
  mbss_pkg::snap_ctrl_t              snap_ctrl;
  logic [MAX_PATTERN_BYTES-1:0][7:0] snap_window;
  logic [POSITION_BITS-1:0]          snap_position;
  logic                              advance;
  logic                              take;

  // A new byte enters whenever the captured stage is empty or moving on.
  assign s_tready = !snap_ctrl.valid || advance;
  assign take     = s_tvalid && s_tready;

  mbss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbss_window #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .POSITION_BITS     (POSITION_BITS)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .advance       (advance),
    .data_byte     (s_tdata),
    .last_byte     (s_tlast),
    .snap_ctrl     (snap_ctrl),
    .snap_window   (snap_window),
    .snap_position (snap_position)
  );

  mbss_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .POSITION_BITS     (POSITION_BITS)
  ) u_match (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .snap_ctrl     (snap_ctrl),
    .snap_window   (snap_window),
    .snap_position (snap_position),
    .out_ready     (m_tready),
    .advance       (advance),
    .out_valid     (m_tvalid),
    .out_found     (m_tuser),
    .out_address   (m_tdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/mbss_checker.sv -----
// Port-level checks for the masked byte signature scanner, bound to the top.
// Depends on mbss_pkg and masked_byte_signature_scan_top.
`default_nettype none

module mbss_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [mbss_pkg::ADDR_W-1:0]    m_tdata,
  input wire logic                           m_tuser
);

  // A stalled result beat holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // A not-found result carries a zero address.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("not-found result with nonzero address");

  // A fresh result comes from a taken byte, held in the window stage and then in the result register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a preceding input beat");

  // With the output empty, the input side is never stalled.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

endmodule

bind masked_byte_signature_scan_top mbss_checker u_mbss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- verif/masked_byte_signature_scan_top_test.sv -----
// Self-checking testbench for masked_byte_signature_scan_top.
// A directed table and random regions are scored beat by beat against a local scan predictor.
// Depends on mbss_pkg and the scanner RTL.
module masked_byte_signature_scan_top_test;

  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic                        found;
    logic [mbss_pkg::ADDR_W-1:0] addr;
  } scan_result_t;

  // One row of the directed table: a register write or a byte beat.
  typedef struct packed {
    logic                            is_cfg;
    logic                            typed;
    logic                            found;
    logic                            last;
    mbss_pkg::reg_index_t            idx;
    logic [7:0]                      data;
    logic [mbss_pkg::CFG_DATA_W-1:0] value;
  } plan_row_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  mbss_pkg::reg_index_t            cfg_index = mbss_pkg::REG_PATTERN_LOW;
  logic [mbss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata   = '0;
  logic                            s_tlast   = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [mbss_pkg::ADDR_W-1:0]     m_tdata;
  logic                            m_tuser;

  // Register mirror and scan state of the predictor.
  logic [mbss_pkg::PATTERN_W-1:0]     pat_mirror  = '0;
  logic [mbss_pkg::PATTERN_W-1:0]     mask_mirror = '0;
  logic [mbss_pkg::LEN_W-1:0]         len_mirror  = mbss_pkg::LEN_W'(1);
  logic [mbss_pkg::OFFSET_W-1:0]      off_mirror  = '0;
  logic [mbss_pkg::ADDR_W-1:0]        base_mirror = '0;
  logic [7:0] window_bytes [mbss_pkg::MAX_PATTERN_BYTES] = '{default: 8'h00};
  logic [mbss_pkg::POSITION_BITS-1:0] pos_count   = '0;
  logic                               hit_seen    = 1'b0;

  scan_result_t scan_results_due [$];
  plan_row_t    plan [$];
  int           mismatch_count = 0;
  int           stalled_cycles = 0;
  bit           calm           = 1'b0;
  bit           squeeze_req    = 1'b0;

  masked_byte_signature_scan_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pattern length in use: zero counts as one, anything above the window is clipped.
  function automatic int active_len();
    if (len_mirror == 0) return 1;
    if (len_mirror > mbss_pkg::MAX_PATTERN_BYTES) return mbss_pkg::MAX_PATTERN_BYTES;
    return int'(len_mirror);
  endfunction

  // Shifts one byte into the window and returns 1 when the byte yields a result.
  function automatic logic scan_byte(input logic [7:0] d, input logic l,
                                     output scan_result_t res);
    int   n;
    logic hit;
    logic emit;
    n    = active_len();
    emit = 1'b0;
    res  = '0;
    for (int i = mbss_pkg::MAX_PATTERN_BYTES - 1; i > 0; i--)
      window_bytes[i] = window_bytes[i-1];
    window_bytes[0] = d;
    if (pos_count != '1) pos_count++;
    if (!hit_seen && pos_count >= n) begin
      hit = 1'b1;
      for (int j = 0; j < n; j++) begin
        if ((window_bytes[n-1-j] & mask_mirror[8*j +: 8]) != pat_mirror[8*j +: 8]) hit = 1'b0;
      end
      if (hit) begin
        res.found = 1'b1;
        res.addr  = base_mirror
                  + mbss_pkg::ADDR_W'(pos_count - mbss_pkg::POSITION_BITS'(n))
                  + {{(mbss_pkg::ADDR_W-mbss_pkg::OFFSET_W){
                        off_mirror[mbss_pkg::OFFSET_W-1]}}, off_mirror};
        hit_seen  = 1'b1;
        emit      = 1'b1;
      end
    end
    // The last byte of a region reports not-found if nothing matched, then clears.
    if (l) begin
      if (!hit_seen) begin
        res  = '0;
        emit = 1'b1;
      end
      window_bytes = '{default: 8'h00};
      pos_count    = '0;
      hit_seen     = 1'b0;
    end
    return emit;
  endfunction

  function automatic plan_row_t cfg_row(input mbss_pkg::reg_index_t idx,
                                        input logic [63:0] value);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = value;
    return r;
  endfunction

  function automatic plan_row_t byte_row(input logic [7:0] d, input logic l);
    plan_row_t r;
    r      = '0;
    r.data = d;
    r.last = l;
    return r;
  endfunction

  function automatic plan_row_t result_row(input logic [7:0] d, input logic l,
                                           input logic f, input logic [63:0] addr);
    plan_row_t r;
    r       = byte_row(d, l);
    r.typed = 1'b1;
    r.found = f;
    r.value = addr;
    return r;
  endfunction

  function automatic logic [63:0] pick_mask();
    case ($urandom_range(0, 4))
      0:       return '1;
      1:       return '0;
      2:       return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom} | {$urandom, $urandom};
    endcase
  endfunction

  // Drives one register write; the caller lowers the write enable after the last one.
  task automatic write_reg(input mbss_pkg::reg_index_t idx,
                           input logic [mbss_pkg::CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      mbss_pkg::REG_PATTERN_LOW:  pat_mirror[63:0]    = value;
      mbss_pkg::REG_PATTERN_HIGH: pat_mirror[127:64]  = value;
      mbss_pkg::REG_MASK_LOW:     mask_mirror[63:0]   = value;
      mbss_pkg::REG_MASK_HIGH:    mask_mirror[127:64] = value;
      mbss_pkg::REG_PATTERN_LEN:  len_mirror          = value[mbss_pkg::LEN_W-1:0];
      mbss_pkg::REG_RESULT_OFF:   off_mirror          = value[mbss_pkg::OFFSET_W-1:0];
      mbss_pkg::REG_BASE_ADDR:    base_mirror         = value;
      default: ;
    endcase
  endtask

  // Offers one byte beat after a random gap and records what it should produce.
  task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                           input logic tf, input logic [63:0] ta);
    int           gap;
    scan_result_t res;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    if (scan_byte(d, l, res) && !typed) scan_results_due.push_back(res);
    if (typed) scan_results_due.push_back(scan_result_t'{found: tf, addr: ta});
  endtask

  // Waits until the block has delivered everything and drained its pipeline.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [63:0] pl, input logic [63:0] ph,
                             input logic [63:0] ml, input logic [63:0] mh,
                             input logic [63:0] len, input logic [63:0] off,
                             input logic [63:0] base);
    settle();
    write_reg(mbss_pkg::REG_PATTERN_LOW, pl);
    write_reg(mbss_pkg::REG_PATTERN_HIGH, ph);
    write_reg(mbss_pkg::REG_MASK_LOW, ml);
    write_reg(mbss_pkg::REG_MASK_HIGH, mh);
    write_reg(mbss_pkg::REG_PATTERN_LEN, len);
    write_reg(mbss_pkg::REG_RESULT_OFF, off);
    write_reg(mbss_pkg::REG_BASE_ADDR, base);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly small lengths; patterns usually fit under the mask so matches can occur.
  task automatic random_config();
    logic [63:0] ml, mh, pl, ph, len, off, base;
    ml = pick_mask();
    mh = pick_mask();
    pl = ($urandom_range(0, 6) == 0) ? {$urandom, $urandom} : ({$urandom, $urandom} & ml);
    ph = ($urandom_range(0, 6) == 0) ? {$urandom, $urandom} : ({$urandom, $urandom} & mh);
    case ($urandom_range(0, 5))
      0:       len = 0;
      1:       len = 1;
      2:       len = mbss_pkg::MAX_PATTERN_BYTES;
      3:       len = $urandom_range(17, 31);
      default: len = $urandom_range(2, 8);
    endcase
    case ($urandom_range(0, 3))
      0:       off = 64'h8000_0000;
      1:       off = 64'h7FFF_FFFF;
      2:       off = 0;
      default: off = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = '1;
      2:       base = $urandom_range(0, 255);
      default: base = {$urandom, $urandom};
    endcase
    load_config(pl, ph, ml, mh, len, off, base);
  endtask

  // One region, usually with the pattern planted at a random start, sometimes spoiled.
  task automatic send_region(input int rlen);
    int         n;
    int         at;
    logic       plant;
    logic [7:0] b;
    n     = active_len();
    plant = (rlen >= n) && ($urandom_range(0, 99) < 75);
    at    = plant ? int'($urandom_range(0, rlen - n)) : -1;
    for (int i = 0; i < rlen; i++) begin
      if (plant && i >= at && i < at + n) begin
        b = (8'($urandom) & ~mask_mirror[8*(i-at) +: 8]) | pat_mirror[8*(i-at) +: 8];
        if ($urandom_range(0, 9) == 0) b ^= 8'(1 << $urandom_range(0, 7));
      end else begin
        b = 8'($urandom);
      end
      send_byte(b, i == rlen - 1, 1'b0, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, with one long hold-off when a squeeze is requested.
  initial begin : drain_results
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (squeeze_req) begin
        stall       = 300;
        squeeze_req = 1'b0;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Compares every result beat with the oldest expected one.
  always @(posedge clk) begin : check_results
    scan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (scan_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: found=%0b addr=%h", m_tuser, m_tdata);
      end else begin
        want = scan_results_due.pop_front();
        if (m_tuser !== want.found || m_tdata !== want.addr) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected found=%0b addr=%h, got found=%0b addr=%h",
                     want.found, want.addr, m_tuser, m_tdata);
        end
      end
    end
  end

  // Ends the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin : stimulus
    int        sent;
    int        rlen;
    plan_row_t row;
    logic      in_cfg;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    plan = '{
      // Reset values: length one with an empty mask matches the first byte.
      result_row(8'hA5, 1'b1, 1'b1, 64'h0),
      // Zero length acts as one; a start of one on an all-ones base wraps to zero.
      cfg_row(mbss_pkg::REG_PATTERN_LEN, 64'd0), cfg_row(mbss_pkg::REG_PATTERN_LOW, 64'hFF),
      cfg_row(mbss_pkg::REG_MASK_LOW, 64'hFF), cfg_row(mbss_pkg::REG_BASE_ADDR, '1),
      byte_row(8'h00, 1'b0), result_row(8'hFF, 1'b1, 1'b1, 64'h0),
      // Oversized length clips to the full window; the match lands on the last byte
      // and the most negative offset cancels the base.
      cfg_row(mbss_pkg::REG_PATTERN_LEN, 64'd31),
      cfg_row(mbss_pkg::REG_PATTERN_LOW, 64'h0706050403020100),
      cfg_row(mbss_pkg::REG_PATTERN_HIGH, 64'h0F0E0D0C0B0A0908),
      cfg_row(mbss_pkg::REG_MASK_LOW, '1),
      cfg_row(mbss_pkg::REG_MASK_HIGH, '1),
      cfg_row(mbss_pkg::REG_RESULT_OFF, 64'h8000_0000),
      cfg_row(mbss_pkg::REG_BASE_ADDR, 64'h8000_0000),
      byte_row(8'h00, 1'b0), byte_row(8'h01, 1'b0), byte_row(8'h02, 1'b0),
      byte_row(8'h03, 1'b0), byte_row(8'h04, 1'b0), byte_row(8'h05, 1'b0),
      byte_row(8'h06, 1'b0), byte_row(8'h07, 1'b0), byte_row(8'h08, 1'b0),
      byte_row(8'h09, 1'b0), byte_row(8'h0A, 1'b0), byte_row(8'h0B, 1'b0),
      byte_row(8'h0C, 1'b0), byte_row(8'h0D, 1'b0), byte_row(8'h0E, 1'b0),
      result_row(8'h0F, 1'b1, 1'b1, 64'h0),
      // A region shorter than the pattern ends as not-found.
      cfg_row(mbss_pkg::REG_PATTERN_LEN, 64'd3),
      byte_row(8'h00, 1'b0), result_row(8'h01, 1'b1, 1'b0, 64'h0),
      // Every byte matches: only the first match reports, the last byte stays silent.
      cfg_row(mbss_pkg::REG_PATTERN_LEN, 64'd1), cfg_row(mbss_pkg::REG_MASK_LOW, 64'h0),
      cfg_row(mbss_pkg::REG_PATTERN_LOW, 64'h0),
      byte_row(8'h3C, 1'b0), byte_row(8'hC3, 1'b0), byte_row(8'h5A, 1'b1),
      // Largest positive offset.
      cfg_row(mbss_pkg::REG_RESULT_OFF, 64'h7FFF_FFFF),
      byte_row(8'hFF, 1'b1)
    };

    // Walk the directed table.
    in_cfg = 1'b0;
    foreach (plan[k]) begin
      row = plan[k];
      if (row.is_cfg) begin
        if (!in_cfg) settle();
        write_reg(row.idx, row.value);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_wr_en <= 1'b0;
        in_cfg = 1'b0;
        send_byte(row.data, row.last, row.typed, row.found, row.value);
      end
    end

    // Random phases, one of them a back-pressure squeeze with a result per byte.
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        load_config('0, '0, '0, '0, 64'd1, $urandom, {$urandom, $urandom});
        calm        = 1'b1;
        squeeze_req = 1'b1;
        repeat (40) send_byte(8'($urandom), 1'b1, 1'b0, 1'b0, '0);
      end else begin
        random_config();
        calm = ($urandom_range(0, 3) == 0);
        sent = 0;
        while (sent < 40) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: rlen = active_len() + $urandom_range(0, 6);
            6, 7:             rlen = $urandom_range(1, active_len());
            default:          rlen = $urandom_range(1, 40);
          endcase
          send_region(rlen);
          sent += rlen;
        end
      end
    end

    settle();
    if (mismatch_count == 0 && scan_results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mbss_pkg.sv
hw/rtl/mbss_cfg.sv
hw/rtl/mbss_window.sv
hw/rtl/mbss_match.sv
hw/rtl/masked_byte_signature_scan_top.sv
hw/rtl/mbss_checker.sv
verif/masked_byte_signature_scan_top_test.sv
